[rtl/opd_pkg.sv]
package opd_pkg;

    localparam int unsigned CHUNK_W      = 13;
    localparam int unsigned FRAME_W      = 11;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned S_TDATA_W    = 24;
    localparam int unsigned M_TDATA_W    = 24;

    localparam logic [CHUNK_W-1:0] MAX_CHUNK_BYTES = 13'd4096;
    localparam logic [BYTE_W-1:0]  LONG_HDR_MIN    = 8'd252;

    typedef enum logic [1:0] {
        PH_DISCARD = 2'd0,
        PH_HEADER  = 2'd1,
        PH_SECOND  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HDR_ERR = 2'd1,
        KIND_OVERRUN = 2'd2
    } kind_t;

endpackage

[rtl/opus_packet_deframer_unit.sv]
// Opus packet deframer.
// Slave channel (s_*): one chunk byte per beat. s_tuser flags the first byte of
// a chunk, which also carries the chunk length in s_tdata. Each chunk is cut into
// packets led by the one- or two-byte Opus length prefix.
// Master channel (m_*): one beat per payload byte (m_tuser = payload, m_tlast on
// the final byte of a packet) or one beat per framing error (partial header,
// packet overrunning the chunk); after an error the rest of the chunk is dropped.
// Header bytes and bytes outside a chunk give no beat.
// Path: an accepted byte is held in the input register, is decoded and lands in
// the output register, from which its result is presented on m_*.
// Throughput: one byte per cycle while m_tready does not stall the output; the
// framing counters are updated as each byte is decoded.
// Reset: aresetn (synchronous, active low) empties both registers and puts the
// framer into discard until the next chunk start.
// Stall: while m_tready is low the output register holds its beat and one more
// byte may still be taken into the input register; then s_tready drops.
module opus_packet_deframer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [opd_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte, [20:8] chunk_length
    input  logic                           s_tuser,  // [0] chunk_first
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [opd_pkg::M_TDATA_W-1:0]  m_tdata,  // [7:0] payload_byte, [18:8] frame_length
    output logic [1:0]                     m_tuser,  // [1:0] kind
    output logic                           m_tlast   // frame_last
);
    import opd_pkg::*;

    // input register
    logic                  in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_first_reg;
    logic [CHUNK_W-1:0]    in_len_reg;

    // framing state
    phase_t                phase_reg, phase_next;
    logic [CHUNK_W-1:0]    chunk_left_reg, chunk_left_next;
    logic [FRAME_W-1:0]    payload_left_reg, payload_left_next;
    logic [BYTE_W-1:0]     first_byte_reg, first_byte_next;
    logic [FRAME_W-1:0]    pkt_length_reg, pkt_length_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_last_reg;
    logic [FRAME_W-1:0]    out_len_reg;

    logic                  advance;

    // state after a possible chunk start
    phase_t                eff_phase;
    logic [CHUNK_W-1:0]    eff_chunk_left;
    logic [FRAME_W-1:0]    eff_payload_left;
    logic [BYTE_W-1:0]     eff_first_byte;
    logic [FRAME_W-1:0]    eff_pkt_length;
    logic [CHUNK_W-1:0     ] sat_len;

    logic                  active;
    logic [CHUNK_W-1:0]    left_after;
    logic [FRAME_W-1:0]    long_len;
    logic                  short_over;
    logic                  long_over;
    logic                  is_short;

    logic                  res_valid;
    kind_t                 res_kind;
    logic [BYTE_W-1:0]     res_byte;
    logic                  res_last;
    logic [FRAME_W-1:0]    res_len;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata[BYTE_W-1:0];
            in_len_reg   <= s_tdata[BYTE_W +: CHUNK_W];
            in_first_reg <= s_tuser;
        end
    end

    // chunk start overrides whatever was left
    always_comb begin
        sat_len = (in_len_reg > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : in_len_reg;
        if (in_first_reg) begin
            eff_phase        = (sat_len == '0) ? PH_DISCARD : PH_HEADER;
            eff_chunk_left   = sat_len;
            eff_payload_left = '0;
            eff_first_byte   = '0;
            eff_pkt_length   = '0;
        end else begin
            eff_phase        = phase_reg;
            eff_chunk_left   = chunk_left_reg;
            eff_payload_left = payload_left_reg;
            eff_first_byte   = first_byte_reg;
            eff_pkt_length   = pkt_length_reg;
        end
    end

    assign active     = (eff_phase != PH_DISCARD) && (eff_chunk_left != '0);
    assign left_after = eff_chunk_left - 1'b1;
    assign is_short   = (in_byte_reg < LONG_HDR_MIN);
    assign short_over = ({{(CHUNK_W-BYTE_W){1'b0}}, in_byte_reg} > left_after);
    assign long_len   = {1'b0, in_byte_reg, 2'b00}
                      + {{(FRAME_W-BYTE_W){1'b0}}, eff_first_byte};
    assign long_over  = ({{(CHUNK_W-FRAME_W){1'b0}}, long_len} > left_after);

    // next framing state
    always_comb begin
        phase_next        = eff_phase;
        chunk_left_next   = eff_chunk_left;
        payload_left_next = eff_payload_left;
        first_byte_next   = eff_first_byte;
        pkt_length_next   = eff_pkt_length;
        if (!active) begin
            phase_next = PH_DISCARD;
        end else begin
            chunk_left_next = left_after;
            unique case (eff_phase)
                PH_HEADER: begin
                    if (is_short) begin
                        pkt_length_next = {{(FRAME_W-BYTE_W){1'b0}}, in_byte_reg};
                        if (in_byte_reg == '0) begin
                            phase_next = (left_after == '0) ? PH_DISCARD : PH_HEADER;
                        end else if (short_over) begin
                            phase_next        = PH_DISCARD;
                            chunk_left_next   = '0;
                            payload_left_next = '0;
                        end else begin
                            payload_left_next = {{(FRAME_W-BYTE_W){1'b0}}, in_byte_reg};
                            phase_next        = PH_PAYLOAD;
                        end
                    end else if (eff_chunk_left < 13'd2) begin
                        phase_next        = PH_DISCARD;
                        chunk_left_next   = '0;
                        payload_left_next = '0;
                    end else begin
                        first_byte_next = in_byte_reg;
                        phase_next      = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    pkt_length_next = long_len;
                    if (long_over) begin
                        phase_next        = PH_DISCARD;
                        chunk_left_next   = '0;
                        payload_left_next = '0;
                    end else begin
                        payload_left_next = long_len;
                        phase_next        = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (eff_payload_left != '0) begin
                        payload_left_next = eff_payload_left - 1'b1;
                    end
                    if (eff_payload_left <= 11'd1) begin
                        phase_next = (left_after == '0) ? PH_DISCARD : PH_HEADER;
                    end else if (left_after == '0) begin
                        phase_next = PH_DISCARD;
                    end
                end
                default: begin
                    phase_next = PH_DISCARD;
                end
            endcase
        end
    end

    // result of this byte
    always_comb begin
        res_valid = 1'b0;
        res_kind  = KIND_PAYLOAD;
        res_byte  = '0;
        res_last  = 1'b0;
        res_len   = '0;
        if (active) begin
            unique case (eff_phase)
                PH_HEADER: begin
                    if (is_short && in_byte_reg != '0 && short_over) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_OVERRUN;
                        res_len   = {{(FRAME_W-BYTE_W){1'b0}}, in_byte_reg};
                    end else if (!is_short && eff_chunk_left < 13'd2) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_HDR_ERR;
                    end
                end
                PH_SECOND: begin
                    if (long_over) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_OVERRUN;
                        res_len   = long_len;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid = 1'b1;
                    res_kind  = KIND_PAYLOAD;
                    res_byte  = in_byte_reg;
                    res_last  = (eff_payload_left <= 11'd1);
                    res_len   = eff_pkt_length;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_DISCARD;
            chunk_left_reg   <= '0;
            payload_left_reg <= '0;
            first_byte_reg   <= '0;
            pkt_length_reg   <= '0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            chunk_left_reg   <= chunk_left_next;
            payload_left_reg <= payload_left_next;
            first_byte_reg   <= first_byte_next;
            pkt_length_reg   <= pkt_length_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
            out_len_reg  <= res_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-BYTE_W-FRAME_W){1'b0}}, out_len_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // an error beat always ends the chunk
    a_err_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid && res_kind != KIND_PAYLOAD |=> phase_reg == PH_DISCARD)
        else $error("framing error did not drop the chunk");

    // a live phase always has chunk bytes behind it
    a_live_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_DISCARD |-> chunk_left_reg != '0)
        else $error("framer active with empty chunk");

    // payload still owed never exceeds what the chunk holds
    a_payload_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> payload_left_reg != '0
            && {{(CHUNK_W-FRAME_W){1'b0}}, payload_left_reg} <= chunk_left_reg)
        else $error("payload count beyond chunk");

    // a held byte is not lost while the output is stalled
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost a beat");

endmodule
